/* rtl/odq_pkg.sv */
// Package for the ordered deque with key removal.
// Holds sizes, operation and status codes and the controller command struct.
// No dependencies.
`default_nettype none

package odq_pkg;

   localparam int CAPACITY    = 16;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int MODE_W      = 3;
   localparam int DATA_W      = 16;
   localparam int STATUS_W    = 2;
   localparam int ENTRY_W     = 5;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 24;

   localparam logic [MODE_W-1:0] MODE_INS_TAIL  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_INS_HEAD  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_LOOKUP    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_REMOVE_ID = 3'd3;
   localparam logic [MODE_W-1:0] MODE_REM_TAIL  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_REM_HEAD  = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic load;
      logic search;
      logic exec;
   } cmd_type;

endpackage

`default_nettype wire

/* rtl/ordered_deque_with_key_removal.sv */
// Top level of the ordered deque with search and removal by key.
// Joins odq_ctrl and odq_datapath; uses odq_pkg.
//
//   channel  direction  handshake            payload
//   req      in         req_tvalid/tready    req_tdata: mode, task_handle, task_id
//   rsp      out        rsp_tvalid/tready    rsp_tdata: status, found_handle, entry_count
//
// Each item goes through accept, parallel key compare over all cells,
// then priority select and cell shift with the result registered.
// A new item is accepted only after the previous item has executed.
// Synchronous reset empties the list; entry contents are not cleared.
// A stalled result holds in the output register; a new item is accepted
// meanwhile and waits in its execute step until the register is free.
`default_nettype none

module ordered_deque_with_key_removal (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // mode [2:0], task_handle [18:3], task_id [34:19], zero [39:35]
   input  wire  [odq_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // status [1:0], found_handle [17:2], entry_count [22:18], zero [23]
   output logic [odq_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import odq_pkg::*;

   cmd_type             cmd;
   logic [STATUS_W-1:0] rsp_status;
   logic [DATA_W-1:0]   rsp_found;
   logic [ENTRY_W-1:0]  rsp_count;

   odq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   odq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_mode   (req_tdata[MODE_W-1:0]),
      .req_handle (req_tdata[MODE_W+DATA_W-1:MODE_W]),
      .req_id     (req_tdata[MODE_W+2*DATA_W-1:MODE_W+DATA_W]),
      .rsp_status (rsp_status),
      .rsp_found  (rsp_found),
      .rsp_count  (rsp_count)
   );

   assign rsp_tdata = {1'b0, rsp_count, rsp_found, rsp_status};

endmodule

`default_nettype wire

/* rtl/odq_datapath.sv */
// Datapath of the ordered deque: request registers, a row of entry cells,
// parallel key compare, priority select and the result register. Uses odq_pkg.
`default_nettype none

module odq_datapath (
   input  wire                          clock,
   input  wire                          reset,
   input  odq_pkg::cmd_type             cmd,
   input  wire  [odq_pkg::MODE_W-1:0]   req_mode,
   input  wire  [odq_pkg::DATA_W-1:0]   req_handle,
   input  wire  [odq_pkg::DATA_W-1:0]   req_id,
   output logic [odq_pkg::STATUS_W-1:0] rsp_status,
   output logic [odq_pkg::DATA_W-1:0]   rsp_found,
   output logic [odq_pkg::ENTRY_W-1:0]  rsp_count
);
   import odq_pkg::*;

   logic [MODE_W-1:0]   mode_ff;
   logic [DATA_W-1:0]   hdl_ff;
   logic [DATA_W-1:0]   key_ff;
   logic [CAPACITY-1:0] match_ff;
   logic [CAPACITY-1:0] match_in;
   logic [DATA_W-1:0]   handle_ff [CAPACITY];
   logic [DATA_W-1:0]   handle_in [CAPACITY];
   logic [DATA_W-1:0]   id_ff     [CAPACITY];
   logic [DATA_W-1:0]   id_in     [CAPACITY];
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic [CNT_W-1:0]    count_dec;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;
   logic [DATA_W-1:0]   found_ff;
   logic [DATA_W-1:0]   found_in;
   logic [IDX_W-1:0]    hit_pos;
   logic                hit;
   logic [IDX_W-1:0]    sel_pos;
   logic                full;
   logic                empty;
   logic                do_tail;
   logic                do_head;
   logic                do_remove;

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         match_in[i] = (id_ff[i] == key_ff) && (CNT_W'(i) < count_ff);
      end
   end

   always_comb begin
      hit_pos = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_pos = IDX_W'(i);
         end
      end
   end

   assign hit       = |match_ff;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign count_dec = count_ff - CNT_W'(1);

   always_comb begin
      status_in = ST_OK;
      found_in  = '0;
      sel_pos   = hit_pos;
      do_tail   = 1'b0;
      do_head   = 1'b0;
      do_remove = 1'b0;
      count_in  = count_ff;
      case (mode_ff)
         MODE_INS_TAIL, MODE_INS_HEAD: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               do_tail  = (mode_ff == MODE_INS_TAIL);
               do_head  = (mode_ff == MODE_INS_HEAD);
               count_in = count_ff + CNT_W'(1);
            end
         end
         MODE_LOOKUP, MODE_REMOVE_ID: begin
            if (hit) begin
               found_in  = handle_ff[sel_pos];
               do_remove = (mode_ff == MODE_REMOVE_ID);
               count_in  = do_remove ? count_dec : count_ff;
            end else begin
               status_in = ST_MISS;
            end
         end
         MODE_REM_TAIL, MODE_REM_HEAD: begin
            sel_pos = (mode_ff == MODE_REM_TAIL) ? count_dec[IDX_W-1:0] : '0;
            if (empty) begin
               status_in = ST_MISS;
            end else begin
               found_in  = handle_ff[sel_pos];
               do_remove = 1'b1;
               count_in  = count_dec;
            end
         end
         default: begin
            status_in = ST_MISS;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         handle_in[i] = handle_ff[i];
         id_in[i]     = id_ff[i];
         if (do_tail && (CNT_W'(i) == count_ff)) begin
            handle_in[i] = hdl_ff;
            id_in[i]     = key_ff;
         end
      end
      if (do_head) begin
         handle_in[0] = hdl_ff;
         id_in[0]     = key_ff;
         for (int i = 1; i < CAPACITY; i++) begin
            handle_in[i] = handle_ff[i-1];
            id_in[i]     = id_ff[i-1];
         end
      end
      if (do_remove) begin
         for (int i = 0; i < CAPACITY - 1; i++) begin
            if (IDX_W'(i) >= sel_pos) begin
               handle_in[i] = handle_ff[i+1];
               id_in[i]     = id_ff[i+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         hdl_ff  <= req_handle;
         key_ff  <= req_id;
      end
      if (cmd.search) begin
         match_ff <= match_in;
      end
      if (cmd.exec) begin
         handle_ff <= handle_in;
         id_ff     <= id_in;
         status_ff <= status_in;
         found_ff  <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   assign rsp_status = status_ff;
   assign rsp_found  = found_ff;
   assign rsp_count  = ENTRY_W'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_full_keeps: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && full && (mode_ff == MODE_INS_TAIL || mode_ff == MODE_INS_HEAD)
      |=> status_ff == ST_FULL && $stable(count_ff))
      else $error("insert into full list changed the count");

endmodule

`default_nettype wire

/* rtl/odq_ctrl.sv */
// Controller of the ordered deque: sequences load, search and execute steps
// and owns the result valid flag. Uses odq_pkg.
`default_nettype none

module odq_ctrl (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  wire              rsp_tready,
   output odq_pkg::cmd_type cmd
);
   import odq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SEARCH = 3'b010,
      S_EXEC   = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);

   assign cmd.load   = req_tvalid && req_tready;
   assign cmd.search = (state_ff == S_SEARCH);
   assign cmd.exec   = (state_ff == S_EXEC) && slot_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_accept_search: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_SEARCH)
      else $error("accepted item did not start a search");

   a_search_exec: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SEARCH |=> state_ff == S_EXEC)
      else $error("search not followed by execute");

   a_exec_result: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("execute step did not post a result");

endmodule

`default_nettype wire

/* tb/odq_checker.sv */
// Checker for the ordered deque: watches the req and rsp channels, keeps a
// shadow copy of the list, predicts each result and compares it field by field.
// Depends on odq_pkg for sizes, operation codes and status codes.
`timescale 1ns / 100ps

module odq_checker (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   input  wire                              req_tready,
   // mode [2:0], task_handle [18:3], task_id [34:19], zero [39:35]
   input  wire  [odq_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  wire                              rsp_tvalid,
   input  wire                              rsp_tready,
   // status [1:0], found_handle [17:2], entry_count [22:18], zero [23]
   input  wire  [odq_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output int                               error_count,
   output int                               pending_count
);
   import odq_pkg::*;

   typedef struct packed {
      logic [ENTRY_W-1:0]  entries;
      logic [DATA_W-1:0]   handle;
      logic [STATUS_W-1:0] status;
   } outcome_type;

   logic [DATA_W-1:0] shadow_handle [CAPACITY];
   logic [DATA_W-1:0] shadow_id [CAPACITY];
   int                shadow_count = 0;
   outcome_type       awaited_results [$];
   int                mismatches = 0;

   function automatic int find_entry(input logic [DATA_W-1:0] key);
      int pos;
      pos = shadow_count;
      for (int i = shadow_count - 1; i >= 0; i--) begin
         if (shadow_id[i] == key) pos = i;
      end
      return pos;
   endfunction

   function automatic logic [DATA_W-1:0] unlink_entry(input int pos);
      logic [DATA_W-1:0] h;
      h = shadow_handle[pos];
      for (int i = pos; i + 1 < shadow_count; i++) begin
         shadow_handle[i] = shadow_handle[i + 1];
         shadow_id[i]     = shadow_id[i + 1];
      end
      shadow_count--;
      return h;
   endfunction

   function automatic outcome_type apply_operation(input logic [MODE_W-1:0] mode,
                                                   input logic [DATA_W-1:0] handle,
                                                   input logic [DATA_W-1:0] key);
      outcome_type r;
      int          pos;
      r.status = ST_OK;
      r.handle = '0;
      case (mode)
         MODE_INS_TAIL: begin
            if (shadow_count >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               shadow_handle[shadow_count] = handle;
               shadow_id[shadow_count]     = key;
               shadow_count++;
            end
         end
         MODE_INS_HEAD: begin
            if (shadow_count >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               for (int i = shadow_count; i > 0; i--) begin
                  shadow_handle[i] = shadow_handle[i - 1];
                  shadow_id[i]     = shadow_id[i - 1];
               end
               shadow_handle[0] = handle;
               shadow_id[0]     = key;
               shadow_count++;
            end
         end
         MODE_LOOKUP: begin
            pos = find_entry(key);
            if (pos < shadow_count) r.handle = shadow_handle[pos];
            else r.status = ST_MISS;
         end
         MODE_REMOVE_ID: begin
            pos = find_entry(key);
            if (pos < shadow_count) r.handle = unlink_entry(pos);
            else r.status = ST_MISS;
         end
         MODE_REM_TAIL: begin
            if (shadow_count == 0) r.status = ST_MISS;
            else r.handle = unlink_entry(shadow_count - 1);
         end
         MODE_REM_HEAD: begin
            if (shadow_count == 0) r.status = ST_MISS;
            else r.handle = unlink_entry(0);
         end
         default: r.status = ST_MISS;
      endcase
      r.entries = ENTRY_W'(shadow_count);
      return r;
   endfunction

   always @(posedge clock) begin : watch
      outcome_type got;
      outcome_type want;
      if (reset) begin
         awaited_results.delete();
         shadow_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = outcome_type'(rsp_tdata[ENTRY_W+DATA_W+STATUS_W-1:0]);
            if (awaited_results.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: result with none pending: status %0d handle %h entries %0d",
                           $realtime, got.status, got.handle, got.entries);
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               if (got.status !== want.status || got.handle !== want.handle ||
                   got.entries !== want.entries) begin
                  if (mismatches < 10)
                     $display("%0t: status %0d/%0d handle %h/%h entries %0d/%0d (exp/act)",
                              $realtime, want.status, got.status, want.handle,
                              got.handle, want.entries, got.entries);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready)
            awaited_results.push_back(apply_operation(req_tdata[MODE_W-1:0],
                                                      req_tdata[MODE_W+DATA_W-1:MODE_W],
                                                      req_tdata[MODE_W+2*DATA_W-1:MODE_W+DATA_W]));
      end
      error_count   <= mismatches;
      pending_count <= awaited_results.size();
   end

endmodule

/* tb/tb.sv */
// Top of the ordered deque testbench: clock, reset, item stimulus with bursts
// and gaps, a stalling receiver, a watchdog and the verdict.
// Depends on odq_pkg, ordered_deque_with_key_removal and odq_checker.
`timescale 1ns / 100ps

module tb;
   import odq_pkg::*;

   localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
   localparam int RANDOM_ITEMS = 1230;
   localparam int IDLE_LIMIT   = 1000;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   rsp_tready = 1'b0;
   // mode [2:0], task_handle [18:3], task_id [34:19], zero [39:35]
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   wire                    req_tready;
   wire                    rsp_tvalid;
   // status [1:0], found_handle [17:2], entry_count [22:18], zero [23]
   wire  [RSP_TDATA_W-1:0] rsp_tdata;
   int                     error_count;
   int                     pending_count;

   int                     burst_left  = 0;
   int                     ready_left  = 0;
   int                     idle_cycles = 0;
   logic [DATA_W-1:0]      id_base     = '0;

   ordered_deque_with_key_removal i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   odq_checker i_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // receiver: long ready stretches, short ready runs and stall runs
   always @(posedge clock) begin
      if (ready_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b1;
            ready_left = $urandom_range(20, 80);
         end else if ($urandom_range(0, 1) == 1) begin
            rsp_tready <= 1'b1;
            ready_left = $urandom_range(1, 4);
         end else begin
            rsp_tready <= 1'b0;
            ready_left = $urandom_range(1, 12);
         end
      end else begin
         ready_left--;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_item(input logic [MODE_W-1:0] mode,
                            input logic [DATA_W-1:0] handle,
                            input logic [DATA_W-1:0] task_id);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 8);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'({task_id, handle, mode});
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   function automatic logic [DATA_W-1:0] pick_id();
      if ($urandom_range(0, 4) == 0) return DATA_W'($urandom);
      return id_base ^ DATA_W'($urandom_range(0, 11));
   endfunction

   function automatic logic [MODE_W-1:0] pick_mode(input int insert_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return ($urandom_range(0, 1) == 1) ? MODE_SPARE_A : MODE_SPARE_B;
      if ($urandom_range(0, 99) < insert_pct)
         return ($urandom_range(0, 1) == 1) ? MODE_INS_TAIL : MODE_INS_HEAD;
      case ($urandom_range(0, 5))
         0, 1:    return MODE_LOOKUP;
         2, 3:    return MODE_REMOVE_ID;
         4:       return MODE_REM_TAIL;
         default: return MODE_REM_HEAD;
      endcase
   endfunction

   initial begin
      int phase_left;
      int insert_pct;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_item(MODE_REM_HEAD,  16'h0000, 16'h0000);
      send_item(MODE_REM_TAIL,  16'hFFFF, 16'hFFFF);
      send_item(MODE_LOOKUP,    16'h0000, 16'h0000);
      send_item(MODE_REMOVE_ID, 16'hFFFF, 16'hFFFF);
      send_item(MODE_SPARE_A,   16'h0000, 16'h0000);
      send_item(MODE_SPARE_B,   16'hFFFF, 16'hFFFF);
      send_item(MODE_INS_TAIL,  16'h0000, 16'h0000);
      send_item(MODE_INS_HEAD,  16'hFFFF, 16'hFFFF);
      send_item(MODE_INS_TAIL,  16'hAAAA, 16'h0000);
      send_item(MODE_LOOKUP,    16'h1111, 16'h0000);
      send_item(MODE_LOOKUP,    16'h2222, 16'hFFFF);
      send_item(MODE_LOOKUP,    16'h3333, 16'h1234);
      send_item(MODE_REMOVE_ID, 16'h4444, 16'h0000);
      send_item(MODE_LOOKUP,    16'h5555, 16'h0000);
      send_item(MODE_INS_HEAD,  16'h5555, 16'h8000);
      send_item(MODE_REM_TAIL,  16'h6666, 16'h0000);
      send_item(MODE_REMOVE_ID, 16'h7777, 16'hFFFF);
      send_item(MODE_REM_HEAD,  16'h8888, 16'h0000);
      send_item(MODE_REM_TAIL,  16'h9999, 16'h0000);
      drain_results();

      phase_left = 0;
      insert_pct = 70;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 200 == 0) id_base = DATA_W'($urandom);
         if (phase_left == 0) begin
            phase_left = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
               0:       insert_pct = 75;
               1:       insert_pct = 20;
               default: insert_pct = 45;
            endcase
         end
         phase_left--;
         send_item(pick_mode(insert_pct), DATA_W'($urandom), pick_id());
         if (n == RANDOM_ITEMS / 2) drain_results();
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
